// ----- rtl/core/arbec_pkg.sv -----
// Package for the ambiguity resolving bit error counter.
// Holds the sizing constants, operation and register codes, and the lane and merge control types.
// It depends on nothing else.
package arbec_pkg;

    localparam int STREAMS     = 4;
    localparam int MAX_PERMS   = 32;
    localparam int MAX_COLUMNS = 65536;

    localparam int LANE_W   = 5;
    localparam int SEARCH_W = 6;
    localparam int WORD_W   = 8;
    localparam int IDX_W    = 2;
    localparam int CNT_W    = 17;
    localparam int SUM_W    = 19;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [CNT_W-1:0]    COL_LIMIT     = CNT_W'(MAX_COLUMNS);
    localparam logic [SEARCH_W-1:0] SEARCH_MAX    = SEARCH_W'(MAX_PERMS);
    localparam logic [SEARCH_W-1:0] SEARCH_RESET  = SEARCH_W'(1);

    localparam logic OP_WRITE_PERM = 1'b0;
    localparam logic OP_COLUMN     = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_PERMS_IN_USE = REG_IDX_W'(0);

    typedef struct packed {
        logic                    perm_wr;
        logic [LANE_W-1:0]       perm_slot;
        logic [WORD_W-1:0]       perm_word;
        logic                    count_en;
        logic [STREAMS-1:0]      source_bits;
        logic [STREAMS-1:0]      detected_bits;
        logic                    finish;
        logic [CNT_W-1:0]        columns;
        logic [SEARCH_W-1:0]     searched;
    } lane_ctrl_t;

    typedef struct packed {
        logic                    start;
        logic [CNT_W-1:0]        columns;
        logic [SEARCH_W-1:0]     searched;
    } merge_ctrl_t;

endpackage

// ----- rtl/core/arbec_item_if.sv -----
// Input channel interface of the bit error counter: valid, ready and one column or table write.
// Depends on arbec_pkg for the field widths.
interface arbec_item_if
    import arbec_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                operation;
    logic [LANE_W-1:0]   perm_slot;
    logic [WORD_W-1:0]   perm_word;
    logic [STREAMS-1:0]  source_bits;
    logic [STREAMS-1:0]  detected_bits;
    logic                last;

    modport source (
        output valid, operation, perm_slot, perm_word, source_bits, detected_bits, last,
        input  ready
    );

    modport sink (
        input  valid, operation, perm_slot, perm_word, source_bits, detected_bits, last,
        output ready
    );
endinterface

// ----- rtl/core/arbec_result_if.sv -----
// Result channel interface of the bit error counter: valid, ready and one search result.
// Depends on arbec_pkg for the field widths.
interface arbec_result_if
    import arbec_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SUM_W-1:0]    min_errors;
    logic [SUM_W-1:0]    total_bits;
    logic [LANE_W-1:0]   best_permutation;
    logic [STREAMS-1:0]  invert_mask;

    modport source (
        output valid, min_errors, total_bits, best_permutation, invert_mask,
        input  ready
    );

    modport sink (
        input  valid, min_errors, total_bits, best_permutation, invert_mask,
        output ready
    );
endinterface

// ----- rtl/core/arbec_lane.sv -----
// One permutation lane: holds its table entry and per-stream mismatch counters.
// On finish it registers its error sum and inversion mask. Depends on arbec_pkg.
module arbec_lane
    import arbec_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  lane_ctrl_t          ctrl,
    input  logic [LANE_W-1:0]   lane_id,
    output logic [SUM_W-1:0]    sum_reg,
    output logic [STREAMS-1:0]  mask_reg
);

    logic [WORD_W-1:0]   perm_reg;
    logic [CNT_W-1:0]    cnt_reg  [STREAMS];
    logic [CNT_W-1:0]    cnt_next [STREAMS];
    logic [CNT_W-1:0]    inv      [STREAMS];
    logic [IDX_W-1:0]    idx      [STREAMS];
    logic [STREAMS-1:0]  miss;
    logic                active;
    logic [SUM_W-1:0]    sum_next;
    logic [STREAMS-1:0]  mask_next;

    assign active = SEARCH_W'(lane_id) < ctrl.searched;

    always_ff @(posedge clk)
    begin
        if (ctrl.perm_wr && (ctrl.perm_slot == lane_id))
        begin
            perm_reg <= ctrl.perm_word;
        end
    end

    always_comb
    begin
        for (int s = 0; s < STREAMS; s++)
        begin
            idx[s]  = perm_reg[IDX_W*s +: IDX_W];
            miss[s] = ctrl.source_bits[s] ^ ctrl.detected_bits[idx[s]];
            if (ctrl.finish)
            begin
                cnt_next[s] = '0;
            end
            else if (ctrl.count_en && active)
            begin
                cnt_next[s] = cnt_reg[s] + CNT_W'(miss[s]);
            end
            else
            begin
                cnt_next[s] = cnt_reg[s];
            end
        end
    end

    always_comb
    begin
        sum_next  = '0;
        mask_next = '0;
        for (int s = 0; s < STREAMS; s++)
        begin
            inv[s] = ctrl.columns - cnt_reg[s];
            if (cnt_reg[s] < inv[s])
            begin
                sum_next = sum_next + SUM_W'(cnt_reg[s]);
            end
            else
            begin
                sum_next     = sum_next + SUM_W'(inv[s]);
                mask_next[s] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STREAMS; s++)
            begin
                cnt_reg[s] <= '0;
            end
        end
        else
        begin
            for (int s = 0; s < STREAMS; s++)
            begin
                cnt_reg[s] <= cnt_next[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            sum_reg  <= sum_next;
            mask_reg <= mask_next;
        end
    end

endmodule

// ----- rtl/core/arbec_merge.sv -----
// Merging stage: scans the registered lane sums one lane per cycle, keeps the first minimum,
// and holds the result in an output register. Depends on arbec_pkg and arbec_result_if.
module arbec_merge
    import arbec_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  merge_ctrl_t         ctrl,
    input  logic [SUM_W-1:0]    lane_sum  [MAX_PERMS],
    input  logic [STREAMS-1:0]  lane_mask [MAX_PERMS],
    arbec_result_if.source      results,
    output logic                busy
);

    logic                busy_reg;
    logic                busy_next;
    logic [SEARCH_W-1:0] scan_reg;
    logic [SEARCH_W-1:0] scan_next;
    logic [SUM_W-1:0]    best_sum_reg;
    logic [LANE_W-1:0]   best_perm_reg;
    logic [STREAMS-1:0]  best_mask_reg;
    logic [SUM_W-1:0]    total_reg;
    logic                valid_reg;
    logic                valid_next;
    logic [SUM_W-1:0]    min_errors_reg;
    logic [SUM_W-1:0]    total_bits_reg;
    logic [LANE_W-1:0]   best_permutation_reg;
    logic [STREAMS-1:0]  invert_mask_reg;
    logic [LANE_W-1:0]   lane_sel;
    logic                scan_done;
    logic                load;

    assign lane_sel  = scan_reg[LANE_W-1:0];
    assign scan_done = (scan_reg == ctrl.searched);
    assign load      = busy_reg && scan_done && (!valid_reg || results.ready);
    assign busy      = busy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        scan_next = scan_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            scan_next = '0;
        end
        else if (busy_reg && !scan_done)
        begin
            scan_next = scan_reg + SEARCH_W'(1);
        end
        else if (load)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            scan_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            scan_reg  <= scan_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            best_sum_reg <= '1;
            total_reg    <= SUM_W'(ctrl.columns) * SUM_W'(STREAMS);
        end
        else if (busy_reg && !scan_done && (lane_sum[lane_sel] < best_sum_reg))
        begin
            best_sum_reg  <= lane_sum[lane_sel];
            best_perm_reg <= lane_sel;
            best_mask_reg <= lane_mask[lane_sel];
        end
        if (load)
        begin
            min_errors_reg       <= best_sum_reg;
            total_bits_reg       <= total_reg;
            best_permutation_reg <= best_perm_reg;
            invert_mask_reg      <= best_mask_reg;
        end
    end

    assign results.valid            = valid_reg;
    assign results.min_errors       = min_errors_reg;
    assign results.total_bits       = total_bits_reg;
    assign results.best_permutation = best_permutation_reg;
    assign results.invert_mask      = invert_mask_reg;

    // The scan index never runs past the number of searched lanes.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (scan_reg <= ctrl.searched))
        else $error("merge scan index ran past the searched lanes");

    // Once a lane has been taken, the best sum is at most half the bit total.
    a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (scan_reg != '0)) |-> (best_sum_reg <= (total_reg >> 1)))
        else $error("best error sum exceeds half of the bit total");

    // A delivered result never claims more errors than half the bits.
    a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (min_errors_reg <= (total_bits_reg >> 1)))
        else $error("result error count exceeds half of the bit total");

    // A search that starts begins its scan at lane zero.
    a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |=> (busy_reg && (scan_reg == '0)))
        else $error("merge scan did not start from lane zero");

endmodule

// ----- rtl/core/ambiguity_resolving_bit_error_counter.sv -----
// Top level of the ambiguity resolving bit error counter.
// Holds the register port, column counter and sequencer; instantiates arbec_lane and arbec_merge.
//
// Usage: the items channel carries table writes (operation 0) and bit columns (operation 1).
// A table write loads one permutation slot; the table must be written before columns arrive.
// Each accepted column (up to 65536 in a run) updates, in the same cycle, the mismatch counters
// of every searched permutation lane, so in a run columns are taken one per cycle with no gap.
// The column marked last ends the run and moves the sequencer into its sum state, in which the
// lanes register their error sums and masks and clear their counters; the merge stage then
// scans the searched lanes one lane per cycle. The items channel is held not ready from the
// last column until the merge stage has loaded its result into the output register.
// The result waits in an output register: columns of the next run are taken while it waits,
// and only the end of that next run stalls until the receiver takes the earlier transaction.
// The configuration port holds permutations_in_use at byte address 0 and must be written only
// while the block is idle. Reset clears the counters, the result channel and sets the
// register to one; the permutation table holds no defined value until written.
module ambiguity_resolving_bit_error_counter
    import arbec_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    arbec_item_if.sink          items,
    arbec_result_if.source      results
);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [SEARCH_W-1:0]  perms_reg;
    logic [CNT_W-1:0]     col_reg;
    logic [CNT_W-1:0]     col_next;
    logic [SEARCH_W-1:0]  searched;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    logic                 accept;
    logic                 col_accept;
    logic                 room;
    logic                 merge_busy;
    lane_ctrl_t           lane_ctrl;
    merge_ctrl_t          merge_ctrl;
    logic [SUM_W-1:0]     lane_sum  [MAX_PERMS];
    logic [STREAMS-1:0]   lane_mask [MAX_PERMS];

    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_PERMS_IN_USE);
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == REG_PERMS_IN_USE) ? DATA_W'(perms_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perms_reg <= SEARCH_RESET;
        end
        else if (cfg_wr)
        begin
            perms_reg <= pwdata[SEARCH_W-1:0];
        end
    end

    always_comb
    begin
        priority if (perms_reg == '0)
        begin
            searched = SEARCH_W'(1);
        end
        else if (perms_reg > SEARCH_MAX)
        begin
            searched = SEARCH_MAX;
        end
        else
        begin
            searched = perms_reg;
        end
    end

    assign items.ready = (state_reg == ST_RUN);
    assign accept      = items.valid && items.ready;
    assign col_accept  = accept && (items.operation == OP_COLUMN);
    assign room        = (col_reg < COL_LIMIT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (col_accept && items.last)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (!merge_busy)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        col_next = col_reg;
        if (state_reg == ST_SUM)
        begin
            col_next = '0;
        end
        else if (col_accept && room)
        begin
            col_next = col_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
        end
    end

    always_comb
    begin
        lane_ctrl.perm_wr       = accept && (items.operation == OP_WRITE_PERM);
        lane_ctrl.perm_slot     = items.perm_slot;
        lane_ctrl.perm_word     = items.perm_word;
        lane_ctrl.count_en      = col_accept && room;
        lane_ctrl.source_bits   = items.source_bits;
        lane_ctrl.detected_bits = items.detected_bits;
        lane_ctrl.finish        = (state_reg == ST_SUM);
        lane_ctrl.columns       = col_reg;
        lane_ctrl.searched      = searched;
        merge_ctrl.start        = (state_reg == ST_SUM);
        merge_ctrl.columns      = col_reg;
        merge_ctrl.searched     = searched;
    end

    for (genvar g = 0; g < MAX_PERMS; g++)
    begin : g_lane
        arbec_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (lane_ctrl),
            .lane_id  (LANE_W'(g)),
            .sum_reg  (lane_sum[g]),
            .mask_reg (lane_mask[g])
        );
    end

    arbec_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (merge_ctrl),
        .lane_sum  (lane_sum),
        .lane_mask (lane_mask),
        .results   (results),
        .busy      (merge_busy)
    );

endmodule
